// ===== design/chained_rotate_xor_word_cipher_defines.svh =====
// Assertion macros shared by the verification files of the word cipher.
// No dependencies; included by the port checker.
`ifndef CHAINED_ROTATE_XOR_WORD_CIPHER_DEFINES_SVH
`define CHAINED_ROTATE_XOR_WORD_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRXW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cipher check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRXW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cipher check failed");

`endif

// ===== design/crxw_pkg.sv =====
// Shared types, rotation tables and helper functions of the word cipher.
// No dependencies; used by crxw_core and the top level.
package crxw_pkg;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANT   = 1'd1;

    // Variant codes.
    localparam logic [1:0] VAR_PLAIN = 2'd0;
    localparam logic [1:0] VAR_MIX_TWO = 2'd1;
    localparam logic [1:0] VAR_MIX_THREE = 2'd2;

    // Stream widths.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    // Rotation tables indexed by the running table index.
    localparam logic [4:0] TBL_ONE [32] = '{
        5'd12, 5'd29, 5'd3,  5'd7,  5'd15, 5'd17, 5'd24, 5'd9,
        5'd2,  5'd2,  5'd11, 5'd8,  5'd31, 5'd5,  5'd20, 5'd16,
        5'd1,  5'd28, 5'd27, 5'd30, 5'd21, 5'd18, 5'd13, 5'd10,
        5'd23, 5'd22, 5'd14, 5'd4,  5'd6,  5'd19, 5'd25, 5'd26};
    localparam logic [4:0] TBL_TWO [32] = '{
        5'd2,  5'd10, 5'd8,  5'd30, 5'd5,  5'd20, 5'd16, 5'd1,
        5'd29, 5'd12, 5'd28, 5'd3,  5'd7,  5'd18, 5'd17, 5'd24,
        5'd9,  5'd2,  5'd27, 5'd31, 5'd25, 5'd15, 5'd26, 5'd11,
        5'd23, 5'd22, 5'd14, 5'd4,  5'd6,  5'd19, 5'd21, 5'd13};
    localparam logic [4:0] TBL_THREE [32] = '{
        5'd27, 5'd31, 5'd25, 5'd15, 5'd26, 5'd11, 5'd23, 5'd22,
        5'd12, 5'd28, 5'd3,  5'd7,  5'd18, 5'd17, 5'd24, 5'd9,
        5'd2,  5'd2,  5'd10, 5'd8,  5'd30, 5'd5,  5'd20, 5'd16,
        5'd1,  5'd29, 5'd14, 5'd4,  5'd6,  5'd19, 5'd21, 5'd13};

    // One input beat after unpacking.
    typedef struct packed {
        logic        start;
        logic [31:0] key;
        logic [31:0] data;
        logic [2:0]  bytes;
        logic        last;
    } item_t;

    // One result beat before packing.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  bytes;
        logic        last;
    } result_t;

    // Chaining state carried from one word to the next.
    typedef struct packed {
        logic [31:0] chain_key;
        logic [4:0]  table_index;
        logic [31:0] saved_key;
    } chain_t;

    // Rotation amount for a variant; the unused code acts as table three.
    function automatic logic [4:0] rot_amount(input logic [1:0] variant,
                                              input logic [4:0] idx);
        logic [4:0] amt;
        case (variant)
            VAR_PLAIN:   amt = TBL_ONE[idx];
            VAR_MIX_TWO: amt = TBL_TWO[idx];
            default:     amt = TBL_THREE[idx];
        endcase
        return amt;
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] d;
        d = {x, x} >> r;
        return d[31:0];
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] d;
        d = {x, x} << r;
        return d[63:32];
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] x, input logic [2:0] r);
        logic [15:0] d;
        d = {x, x} >> r;
        return d[7:0];
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] r);
        logic [15:0] d;
        d = {x, x} << r;
        return d[15:8];
    endfunction

endpackage

// ===== design/crxw_core.sv =====
// Combinational transform of one beat: full-word chain step or short tail.
// Depends on crxw_pkg for types, tables and rotate helpers.
module crxw_core (
    input  logic                 direction,
    input  logic [1:0]           variant,
    input  crxw_pkg::item_t      item,
    input  crxw_pkg::chain_t     state,
    output crxw_pkg::result_t    result,
    output crxw_pkg::chain_t     state_next
);

    // A start beat reloads the chain before the beat is processed.
    crxw_pkg::chain_t eff;

    always_comb
    begin
        if (item.start)
        begin
            eff.chain_key   = item.key;
            eff.saved_key   = item.key;
            eff.table_index = 5'd0;
        end
        else
        begin
            eff = state;
        end
    end

    // Full-word path.
    logic [4:0]  amt;
    logic [3:0]  shamt;
    logic [4:0]  shamt_inv;
    logic        mix;
    logic [31:0] word_mid;
    logic [31:0] word_res;
    logic [4:0]  word_idx;

    assign amt       = crxw_pkg::rot_amount(variant, eff.table_index);
    assign shamt     = eff.chain_key[3:0];
    assign shamt_inv = 5'd16 - {1'b0, shamt};
    assign mix       = (variant != crxw_pkg::VAR_PLAIN);

    always_comb
    begin
        logic [31:0] x;
        logic [15:0] ha;
        logic [15:0] hb;
        if (!direction)
        begin
            // Encrypt: rotate, key, then optional half mixing.
            x  = crxw_pkg::rotr32(item.data, amt) ^ eff.chain_key;
            ha = x[15:0] + (x[31:16] >> shamt);
            hb = x[31:16] + (ha >> shamt_inv);
            word_mid = x;
            word_res = mix ? {hb, ha} : x;
            word_idx = word_res[28:24];
        end
        else
        begin
            // Decrypt: undo mixing, then key and rotate back.
            hb = item.data[31:16] - (item.data[15:0] >> shamt_inv);
            ha = item.data[15:0] - (hb >> shamt);
            x  = mix ? {hb, ha} : item.data;
            word_mid = x;
            word_res = crxw_pkg::rotl32(x ^ eff.chain_key, amt);
            word_idx = item.data[28:24];
        end
    end

    // Tail path: up to three bytes with a running byte rotation.
    logic [31:0] tail_res;

    always_comb
    begin
        logic [2:0] n;
        logic [7:0] xb;
        logic [7:0] kb;
        logic [7:0] yb;
        n = eff.table_index[2:0];
        tail_res = '0;
        for (int j = 0; j < 3; j++)
        begin
            xb = item.data[8*j +: 8];
            kb = eff.saved_key[8*j +: 8];
            if (!direction)
            begin
                yb = crxw_pkg::rotr8(xb, n) ^ kb;
                if (item.bytes > 3'(j))
                    n = yb[2:0];
            end
            else
            begin
                yb = crxw_pkg::rotl8(xb ^ kb, n);
                if (item.bytes > 3'(j))
                    n = xb[2:0];
            end
            if (item.bytes > 3'(j))
                tail_res[8*j +: 8] = yb;
        end
    end

    // Select the path by the byte count; only a full word moves the chain.
    always_comb
    begin
        result.bytes = item.bytes;
        result.last  = item.last;
        state_next   = eff;
        if (item.bytes[2])
        begin
            result.data            = word_res;
            state_next.chain_key   = word_mid;
            state_next.table_index = word_idx;
        end
        else
        begin
            result.data = tail_res;
        end
    end

endmodule

// ===== design/chained_rotate_xor_word_cipher.sv =====
// Top level of the chained rotate-xor word cipher: stream ports, input and
// result registers, chain state and configuration. Uses crxw_pkg, crxw_core.
//
//   channel   direction  beat carries
//   s_axis    in         key, data, byte count; tuser = start, tlast = last
//   m_axis    out        data, byte count; tlast = last
//   cfg       in         register writes, no handshake
//
// One beat per cycle unless m_axis stalls; a taken beat passes the input
// register, then the result register. The chain key and table index update
// as a beat leaves the input register, so the following beat uses them.
// Reset clears the chain state and both valid flags; direction resets to
// encrypt and variant to mixing with table two.
// A stall on m_axis holds the result register and then the input register.
module chained_rotate_xor_word_cipher (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // message_key[31:0], in_data[63:32], in_bytes[66:64], zero fill above
    input  logic [crxw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // start_of_message[0]
    input  logic [0:0]                         s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_data[31:0], out_bytes[34:32], zero fill above
    output logic [crxw_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [crxw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crxw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // Configuration registers.
    logic       direction_reg;
    logic [1:0] variant_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            variant_reg   <= crxw_pkg::VAR_MIX_TWO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crxw_pkg::REG_DIRECTION: direction_reg <= cfg_wdata[0];
                crxw_pkg::REG_VARIANT:   variant_reg   <= cfg_wdata;
            endcase
        end
    end

    // Pipeline flow control.
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic in_adv;

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign in_adv        = in_valid_reg && out_adv;
    assign s_axis_tready = !in_valid_reg || out_adv;

    // Input register.
    crxw_pkg::item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.start <= s_axis_tuser[0];
            item_reg.key   <= s_axis_tdata[31:0];
            item_reg.data  <= s_axis_tdata[63:32];
            item_reg.bytes <= s_axis_tdata[66:64];
            item_reg.last  <= s_axis_tlast;
        end
    end

    // Transform.
    crxw_pkg::chain_t  chain_reg;
    crxw_pkg::chain_t  chain_next;
    crxw_pkg::result_t result_next;

    crxw_core u_core (
        .direction  (direction_reg),
        .variant    (variant_reg),
        .item       (item_reg),
        .state      (chain_reg),
        .result     (result_next),
        .state_next (chain_next)
    );

    // Chain state advances as a beat moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain_reg <= '0;
        else if (in_adv)
            chain_reg <= chain_next;
    end

    // Result register.
    crxw_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_adv)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, result_reg.bytes, result_reg.data};
    assign m_axis_tlast  = result_reg.last;

endmodule

// ===== design/crxw_checker.sv =====
// Port-level checks on the word cipher, bound to the top level.
// Depends on chained_rotate_xor_word_cipher_defines.svh for the macros.
`include "chained_rotate_xor_word_cipher_defines.svh"

module crxw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result beat keeps its contents.
    `CRXW_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Input back-pressure only comes from a stalled output.
    `CRXW_ASSERT_NOW(a_ready_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // A taken beat shows at the output once the output is free.
    `CRXW_ASSERT_NEXT(a_latency, clk, rst_n, (s_axis_tvalid && s_axis_tready) ##1 (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)

endmodule

bind chained_rotate_xor_word_cipher crxw_checker u_crxw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/chained_rotate_xor_word_cipher_tb.sv =====
// Self-checking testbench for chained_rotate_xor_word_cipher: directed vectors, then
// random messages over every direction and variant setting, checked by a local predictor.
// Depends on crxw_pkg and the top level chained_rotate_xor_word_cipher.
module chained_rotate_xor_word_cipher_tb;

    localparam int CLK_PERIOD    = 12;
    localparam int TIMEOUT_CYCLES = 800_000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 10;
    localparam int PHASE_BEATS   = 133;
    localparam int MAX_REPORTS   = 10;

    // Direction codes and the spare variant code, which acts as table three.
    localparam logic       DIR_ENC   = 1'b0;
    localparam logic       DIR_DEC   = 1'b1;
    localparam logic [1:0] VAR_SPARE = 2'd3;

    // Rotation amounts per table index, one table per variant.
    localparam logic [4:0] ROT_PLAIN [32] = '{
        5'd12, 5'd29, 5'd3,  5'd7,  5'd15, 5'd17, 5'd24, 5'd9,
        5'd2,  5'd2,  5'd11, 5'd8,  5'd31, 5'd5,  5'd20, 5'd16,
        5'd1,  5'd28, 5'd27, 5'd30, 5'd21, 5'd18, 5'd13, 5'd10,
        5'd23, 5'd22, 5'd14, 5'd4,  5'd6,  5'd19, 5'd25, 5'd26};
    localparam logic [4:0] ROT_TWO [32] = '{
        5'd2,  5'd10, 5'd8,  5'd30, 5'd5,  5'd20, 5'd16, 5'd1,
        5'd29, 5'd12, 5'd28, 5'd3,  5'd7,  5'd18, 5'd17, 5'd24,
        5'd9,  5'd2,  5'd27, 5'd31, 5'd25, 5'd15, 5'd26, 5'd11,
        5'd23, 5'd22, 5'd14, 5'd4,  5'd6,  5'd19, 5'd21, 5'd13};
    localparam logic [4:0] ROT_THREE [32] = '{
        5'd27, 5'd31, 5'd25, 5'd15, 5'd26, 5'd11, 5'd23, 5'd22,
        5'd12, 5'd28, 5'd3,  5'd7,  5'd18, 5'd17, 5'd24, 5'd9,
        5'd2,  5'd2,  5'd10, 5'd8,  5'd30, 5'd5,  5'd20, 5'd16,
        5'd1,  5'd29, 5'd14, 5'd4,  5'd6,  5'd19, 5'd21, 5'd13};

    // One directed vector: the setting it runs under, the beat, and an optional
    // hand-computed output word.
    typedef struct packed {
        logic              dir;
        logic [1:0]        mode;
        crxw_pkg::item_t   beat;
        logic              typed;
        logic [31:0]       want;
    } vector_t;

    localparam vector_t DIRECTED_VECTORS [25] = '{
        // Reset setting: encrypt with mixing table two.
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b1, 32'h0000_0000, 32'h0000_0000, 3'd4, 1'b0},
          1'b1, 32'h0000_0000},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 3'd4, 1'b0},
          1'b0, 32'h0},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 3'd0, 1'b0},
          1'b1, 32'h0000_0000},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'h0000_0000, 32'hA5A5_A5A5, 3'd2, 1'b0},
          1'b0, 32'h0},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'h0000_0000, 32'hDEAD_BEEF, 3'd7, 1'b0},
          1'b0, 32'h0},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'h0000_0000, 32'h0000_003C, 3'd1, 1'b1},
          1'b0, 32'h0},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'h0000_0000, 32'h1122_3344, 3'd4, 1'b0},
          1'b0, 32'h0},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b1, 32'h0000_00A5, 32'hFFFF_FF3C, 3'd1, 1'b1},
          1'b1, 32'h0000_0099},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b0},
          1'b0, 32'h0},
        '{DIR_ENC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'h0000_0000, 32'h0000_0000, 3'd3, 1'b1},
          1'b0, 32'h0},
        // Plain rotate-xor: a lone bit moves down by the first table entry.
        '{DIR_ENC, crxw_pkg::VAR_PLAIN, '{1'b1, 32'h0000_0000, 32'h0000_1000, 3'd4, 1'b0},
          1'b1, 32'h0000_0001},
        '{DIR_ENC, crxw_pkg::VAR_PLAIN, '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 3'd5, 1'b0},
          1'b0, 32'h0},
        '{DIR_ENC, crxw_pkg::VAR_PLAIN, '{1'b0, 32'h0000_0000, 32'h8000_0001, 3'd3, 1'b1},
          1'b0, 32'h0},
        // Mixing with a chain key whose low nibble is zero (half shifted by sixteen).
        '{DIR_ENC, crxw_pkg::VAR_MIX_THREE, '{1'b1, 32'h0000_FFF0, 32'hCAFE_F00D, 3'd4, 1'b0},
          1'b0, 32'h0},
        '{DIR_ENC, crxw_pkg::VAR_MIX_THREE, '{1'b0, 32'h0000_0000, 32'h0000_0000, 3'd6, 1'b1},
          1'b0, 32'h0},
        '{DIR_ENC, VAR_SPARE, '{1'b1, 32'h89AB_CDEF, 32'h0123_4567, 3'd4, 1'b0},
          1'b0, 32'h0},
        '{DIR_ENC, VAR_SPARE, '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 3'd2, 1'b1},
          1'b0, 32'h0},
        // Decrypt.
        '{DIR_DEC, crxw_pkg::VAR_MIX_TWO, '{1'b1, 32'h0000_0000, 32'h0000_0000, 3'd4, 1'b0},
          1'b1, 32'h0000_0000},
        '{DIR_DEC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 3'd4, 1'b0},
          1'b0, 32'h0},
        '{DIR_DEC, crxw_pkg::VAR_MIX_TWO, '{1'b0, 32'h0000_0000, 32'h0000_0055, 3'd1, 1'b1},
          1'b0, 32'h0},
        '{DIR_DEC, crxw_pkg::VAR_PLAIN, '{1'b1, 32'h0000_0000, 32'h0000_0001, 3'd4, 1'b0},
          1'b1, 32'h0000_1000},
        '{DIR_DEC, crxw_pkg::VAR_PLAIN, '{1'b0, 32'h0000_0000, 32'h0000_0007, 3'd3, 1'b1},
          1'b0, 32'h0},
        '{DIR_DEC, crxw_pkg::VAR_MIX_THREE, '{1'b1, 32'h1234_0000, 32'hFFFF_0000, 3'd4, 1'b0},
          1'b0, 32'h0},
        '{DIR_DEC, crxw_pkg::VAR_MIX_THREE, '{1'b0, 32'h0000_0000, 32'h00AB_CDEF, 3'd3, 1'b1},
          1'b0, 32'h0},
        '{DIR_DEC, VAR_SPARE, '{1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 3'd4, 1'b1},
          1'b0, 32'h0}
    };

    // Settings visited by the random phases, extremes included.
    localparam logic       PHASE_DIR  [PHASES] = '{DIR_ENC, DIR_DEC, DIR_ENC, DIR_DEC,
        DIR_ENC, DIR_DEC, DIR_ENC, DIR_DEC, DIR_ENC, DIR_DEC};
    localparam logic [1:0] PHASE_MODE [PHASES] = '{
        crxw_pkg::VAR_MIX_TWO, crxw_pkg::VAR_MIX_TWO,
        crxw_pkg::VAR_PLAIN, crxw_pkg::VAR_PLAIN,
        crxw_pkg::VAR_MIX_THREE, crxw_pkg::VAR_MIX_THREE,
        VAR_SPARE, VAR_SPARE,
        crxw_pkg::VAR_MIX_TWO, crxw_pkg::VAR_MIX_THREE};

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [crxw_pkg::S_TDATA_W-1:0]    s_axis_tdata;
    logic [0:0]                        s_axis_tuser;
    logic                              s_axis_tlast;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [crxw_pkg::M_TDATA_W-1:0]    m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              cfg_we;
    logic [crxw_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [crxw_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    // Predictor copy of the setting and the chaining state.
    logic        cur_dir;
    logic [1:0]  cur_mode;
    logic [31:0] chain_key;
    logic [4:0]  tbl_pos;
    logic [31:0] tail_key;

    crxw_pkg::result_t pending_results [$];
    int      errors;
    int      beats_sent;
    int      results_seen;
    int      settings_used;
    int      long_holds;
    bit      steady;
    bit      hold_req;

    chained_rotate_xor_word_cipher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Bit rotations on whole words and on single bytes.
    function automatic logic [31:0] ror32(input logic [31:0] x, input int r);
        r = r % 32;
        if (r == 0)
            return x;
        return (x >> r) | (x << (32 - r));
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
        r = r % 32;
        if (r == 0)
            return x;
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [7:0] ror8(input logic [7:0] x, input int r);
        r = r % 8;
        if (r == 0)
            return x;
        return (x >> r) | (x << (8 - r));
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] x, input int r);
        r = r % 8;
        if (r == 0)
            return x;
        return (x << r) | (x >> (8 - r));
    endfunction

    // Computes the output beat for one accepted input beat and advances the chain.
    function automatic crxw_pkg::result_t cipher_step(input crxw_pkg::item_t beat);
        crxw_pkg::result_t r;
        logic [1:0]  m;
        logic [4:0]  amt;
        int          s;
        int          n;
        logic [31:0] mid;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [7:0]  x;
        logic [7:0]  kb;
        logic [7:0]  y;
        if (beat.start)
        begin
            chain_key = beat.key;
            tail_key  = beat.key;
            tbl_pos   = '0;
        end
        r.data  = '0;
        r.bytes = beat.bytes;
        r.last  = beat.last;
        m = (cur_mode > crxw_pkg::VAR_MIX_THREE) ? crxw_pkg::VAR_MIX_THREE : cur_mode;
        if (beat.bytes >= 3'd4)
        begin
            // Full word: table rotation, chain XOR, optional half mixing.
            case (m)
                crxw_pkg::VAR_PLAIN:   amt = ROT_PLAIN[tbl_pos];
                crxw_pkg::VAR_MIX_TWO: amt = ROT_TWO[tbl_pos];
                default:               amt = ROT_THREE[tbl_pos];
            endcase
            s = int'(chain_key[3:0]);
            if (cur_dir == DIR_ENC)
            begin
                mid    = ror32(beat.data, int'(amt)) ^ chain_key;
                r.data = mid;
                if (m != crxw_pkg::VAR_PLAIN)
                begin
                    lo = mid[15:0];
                    hi = mid[31:16];
                    lo = lo + (hi >> s);
                    hi = hi + (lo >> (16 - s));
                    r.data = {hi, lo};
                end
                tbl_pos = r.data[28:24];
            end
            else
            begin
                mid = beat.data;
                if (m != crxw_pkg::VAR_PLAIN)
                begin
                    lo  = beat.data[15:0];
                    hi  = beat.data[31:16];
                    hi  = hi - (lo >> (16 - s));
                    lo  = lo - (hi >> s);
                    mid = {hi, lo};
                end
                r.data  = rol32(mid ^ chain_key, int'(amt));
                tbl_pos = beat.data[28:24];
            end
            chain_key = mid;
        end
        else if (beat.bytes != 3'd0)
        begin
            // Short tail: per-byte rotation with a running amount and key bytes.
            n = int'(tbl_pos[2:0]);
            for (int j = 0; j < beat.bytes; j++)
            begin
                x  = beat.data[8*j +: 8];
                kb = tail_key[8*j +: 8];
                if (cur_dir == DIR_ENC)
                begin
                    y = ror8(x, n) ^ kb;
                    n = int'(y[2:0]);
                end
                else
                begin
                    y = rol8(x ^ kb, n);
                    n = int'(x[2:0]);
                end
                r.data[8*j +: 8] = y;
            end
        end
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Mostly short gaps, now and then a long one, none in steady stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Offers one beat after a random gap and records its output once taken.
    task automatic send_item(input crxw_pkg::item_t beat, input logic typed,
                             input logic [31:0] want);
        int                gap;
        crxw_pkg::result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, beat.bytes, beat.data, beat.key};
        s_axis_tuser  <= beat.start;
        s_axis_tlast  <= beat.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = cipher_step(beat);
        if (typed)
            r.data = want;
        pending_results.push_back(r);
        beats_sent++;
    endtask

    // Sends one message of mostly full words closed by a last beat of one to four bytes.
    task automatic send_message(input logic with_start);
        crxw_pkg::item_t beat;
        int              nwords;
        nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
        beat.key = rand_word();
        for (int k = 0; k <= nwords; k++)
        begin
            beat.start = with_start && (k == 0);
            beat.data  = rand_word();
            beat.last  = (k == nwords);
            if (k == nwords)
                beat.bytes = 3'($urandom_range(1, 4));
            else
                beat.bytes = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(1, 7)) : 3'd4;
            send_item(beat, 1'b0, 32'h0);
        end
    endtask

    // Stops offering beats and waits until every expected beat has come out.
    task automatic wait_drained();
        int spins;
        s_axis_tvalid <= 1'b0;
        spins = 0;
        while (pending_results.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (pending_results.size() != 0)
        begin
            flag_error($sformatf("%0d output beats never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on consecutive cycles; only called while idle.
    task automatic set_mode(input logic dir, input logic [1:0] mode);
        cfg_we    <= 1'b1;
        cfg_index <= crxw_pkg::REG_DIRECTION;
        cfg_wdata <= {1'b0, dir};
        @(posedge clk);
        cfg_index <= crxw_pkg::REG_VARIANT;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_dir  = dir;
        cur_mode = mode;
        settings_used++;
    endtask

    // Output side: random stalls, plus one long hold-off when requested.
    initial
    begin : output_stalls
        int hold_cnt;
        int stall;
        hold_cnt = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
                long_holds++;
            end
            else if (hold_cnt > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt--;
            end
            else
            begin
                stall = pick_gap();
                m_axis_tready <= (stall == 0);
                if (stall > 0)
                    hold_cnt = stall - 1;
            end
        end
    end

    // Compares every output beat with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        crxw_pkg::result_t got;
        crxw_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data  = m_axis_tdata[31:0];
            got.bytes = m_axis_tdata[34:32];
            got.last  = m_axis_tlast;
            results_seen++;
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected output beat data=%h bytes=%0d last=%b",
                                     got.data, got.bytes, got.last));
            else
            begin
                want = pending_results.pop_front();
                if (got.data !== want.data || got.bytes !== want.bytes ||
                    got.last !== want.last)
                    flag_error($sformatf({"beat mismatch: expected data=%h bytes=%0d ",
                                          "last=%b, got data=%h bytes=%0d last=%b"},
                                         want.data, want.bytes, want.last,
                                         got.data, got.bytes, got.last));
            end
        end
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: reset, directed vectors, then random phases over all settings.
    initial
    begin : stimulus
        crxw_pkg::item_t beat;
        int              base;
        int              r;
        bit              paused;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= crxw_pkg::REG_DIRECTION;
        cfg_wdata     <= '0;
        cur_dir   = DIR_ENC;
        cur_mode  = crxw_pkg::VAR_MIX_TWO;
        chain_key = '0;
        tbl_pos   = '0;
        tail_key  = '0;
        errors = 0;
        beats_sent = 0;
        results_seen = 0;
        settings_used = 0;
        long_holds = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed vectors; a change of setting waits for the block to go idle.
        foreach (DIRECTED_VECTORS[i])
        begin
            if (DIRECTED_VECTORS[i].dir != cur_dir || DIRECTED_VECTORS[i].mode != cur_mode)
            begin
                wait_drained();
                set_mode(DIRECTED_VECTORS[i].dir, DIRECTED_VECTORS[i].mode);
            end
            send_item(DIRECTED_VECTORS[i].beat, DIRECTED_VECTORS[i].typed,
                      DIRECTED_VECTORS[i].want);
        end

        // Random phases: mostly well-formed messages, some continuations and noise.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            set_mode(PHASE_DIR[p], PHASE_MODE[p]);
            steady = (p == 3 || p == 7);
            if (p == 3)
                hold_req = 1'b1;
            base = beats_sent;
            while (beats_sent - base < PHASE_BEATS)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_message(1'b1);
                else if (r < 85)
                    send_message(1'b0);
                else
                begin
                    beat.start = 1'($urandom_range(0, 1));
                    beat.key   = rand_word();
                    beat.data  = rand_word();
                    beat.bytes = 3'($urandom_range(0, 7));
                    beat.last  = 1'($urandom_range(0, 1));
                    send_item(beat, 1'b0, 32'h0);
                end
                // Once, the input side pauses mid-phase until the block is empty.
                if (p == 5 && !paused && beats_sent - base > PHASE_BEATS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            steady = 1'b0;
        end

        wait_drained();
        $display("Sent %0d input beats and checked %0d output beats under %0d settings,",
                 beats_sent, results_seen, settings_used);
        $display("with %0d long output hold-offs and %0d errors.", long_holds, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/crxw_pkg.sv
design/crxw_core.sv
design/chained_rotate_xor_word_cipher.sv
design/crxw_checker.sv
verif/chained_rotate_xor_word_cipher_tb.sv
